// ----- hw/rtl/b64_pkg.sv -----
// Shared types, character constants and alphabet functions for the Base64 codec.
// Used by every module of base64_stream_codec; depends on nothing.
package b64_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    // One unit of work for the back end: up to four result bytes in order.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      count;
        logic            end_flag;
    } job_t;

    // Sextet value to alphabet character.
    function automatic logic [7:0] b64_encode_char(input logic [5:0] v);
        logic [7:0] wide;
        wide = {2'b00, v};
        if (v < 6'd26) begin
            return wide + 8'h41;
        end else if (v < 6'd52) begin
            return wide + 8'h47;
        end else if (v < 6'd62) begin
            return wide - 8'd4;
        end else if (v == 6'd62) begin
            return CHAR_PLUS;
        end else begin
            return CHAR_SLASH;
        end
    endfunction

    // Character to {valid, sextet}; valid is low for '=' and anything outside the alphabet.
    function automatic logic [6:0] b64_decode_char(input logic [7:0] c);
        logic [7:0] diff;
        diff = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            diff = c - 8'h41;
            return {1'b1, diff[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            diff = c - 8'h47;
            return {1'b1, diff[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            diff = c + 8'd4;
            return {1'b1, diff[5:0]};
        end else if (c == CHAR_PLUS) begin
            return {1'b1, 6'd62};
        end else if (c == CHAR_SLASH) begin
            return {1'b1, 6'd63};
        end else begin
            return 7'd0;
        end
    endfunction

endpackage

// ----- hw/rtl/b64_front.sv -----
// Front end of the Base64 codec: accepts requests, keeps the group state and the
// mode register, and builds one job per request that produces results. Uses b64_pkg.
module b64_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    input  logic          cfg_data,
    input  logic          in_fire,
    input  logic [7:0]    in_byte,
    input  logic          in_end,
    output logic          job_valid,
    output b64_pkg::job_t job
);
    import b64_pkg::*;

    mode_t       mode_reg,    mode_next;
    logic [23:0] bits_reg,    bits_next;
    logic [1:0]  cnt_reg,     cnt_next;
    logic        stopped_reg, stopped_next;

    logic [23:0] enc_full;
    logic [23:0] dec_full;
    logic [23:0] flush_bits;
    logic [6:0]  dec_char;

    always_comb begin
        mode_next    = mode_reg;
        bits_next    = bits_reg;
        cnt_next     = cnt_reg;
        stopped_next = stopped_reg;
        job          = '0;
        job.end_flag = in_end;
        enc_full     = {bits_reg[15:0], in_byte};
        dec_char     = b64_decode_char(in_byte);
        dec_full     = {bits_reg[17:0], dec_char[5:0]};
        flush_bits   = '0;

        if (cfg_valid) begin
            mode_next    = mode_t'(cfg_data);
            bits_next    = '0;
            cnt_next     = '0;
            stopped_next = 1'b0;
        end else if (in_fire) begin
            unique case (mode_reg)
                MODE_ENCODE: begin
                    if (cnt_reg == 2'd2) begin
                        job.data[0] = b64_encode_char(enc_full[23:18]);
                        job.data[1] = b64_encode_char(enc_full[17:12]);
                        job.data[2] = b64_encode_char(enc_full[11:6]);
                        job.data[3] = b64_encode_char(enc_full[5:0]);
                        job.count   = 3'd4;
                        bits_next   = '0;
                        cnt_next    = '0;
                    end else begin
                        bits_next = enc_full;
                        cnt_next  = cnt_reg + 2'd1;
                    end
                    if (in_end && cnt_next != 2'd0) begin
                        // Partial group: missing bytes are zero, missing characters pad.
                        flush_bits  = (cnt_next == 2'd1) ? {enc_full[7:0], 16'd0}
                                                         : {enc_full[15:0], 8'd0};
                        job.data[0] = b64_encode_char(flush_bits[23:18]);
                        job.data[1] = b64_encode_char(flush_bits[17:12]);
                        job.data[2] = (cnt_next == 2'd2) ?
                                      b64_encode_char(flush_bits[11:6]) : CHAR_PAD;
                        job.data[3] = CHAR_PAD;
                        job.count   = 3'd4;
                    end
                end
                MODE_DECODE: begin
                    if (!stopped_reg) begin
                        if (!dec_char[6]) begin
                            stopped_next = 1'b1;
                        end else if (cnt_reg == 2'd3) begin
                            job.data[0] = dec_full[23:16];
                            job.data[1] = dec_full[15:8];
                            job.data[2] = dec_full[7:0];
                            job.count   = 3'd3;
                            bits_next   = '0;
                            cnt_next    = '0;
                        end else begin
                            bits_next = dec_full;
                            cnt_next  = cnt_reg + 2'd1;
                        end
                    end
                    if (in_end && cnt_next >= 2'd2) begin
                        // Two characters give one byte, three give two.
                        flush_bits  = (cnt_next == 2'd2) ? {bits_next[11:0], 12'd0}
                                                         : {bits_next[17:0], 6'd0};
                        job.data[0] = flush_bits[23:16];
                        job.data[1] = flush_bits[15:8];
                        job.count   = (cnt_next == 2'd3) ? 3'd2 : 3'd1;
                    end
                end
                default: begin
                    job.count = '0;
                end
            endcase
            if (in_end) begin
                bits_next    = '0;
                cnt_next     = '0;
                stopped_next = 1'b0;
            end
        end
    end

    assign job_valid = in_fire && (job.count != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_ENCODE;
            bits_reg    <= '0;
            cnt_reg     <= '0;
            stopped_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            bits_reg    <= bits_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// ----- hw/rtl/b64_queue.sv -----
// Small job queue between the front and back ends of the Base64 codec.
// Uses b64_pkg for the job type.
module b64_queue #(
    parameter int DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  b64_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output b64_pkg::job_t pop_job
);
    import b64_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_job    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- hw/rtl/b64_back.sv -----
// Back end of the Base64 codec: holds one job and hands out its bytes one
// result per cycle while m_ready is high. Uses b64_pkg for the job type.
module b64_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  b64_pkg::job_t job,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_run_last,
    output logic          m_msg_done
);
    import b64_pkg::*;

    job_t       cur_reg,  cur_next;
    logic [1:0] idx_reg,  idx_next;
    logic       busy_reg, busy_next;
    logic       last;

    assign last       = ({1'b0, idx_reg} == (cur_reg.count - 3'd1));
    assign m_valid    = busy_reg;
    assign m_out_byte = cur_reg.data[idx_reg];
    assign m_run_last = last;
    assign m_msg_done = last && cur_reg.end_flag;
    assign job_ready  = !busy_reg || (m_ready && last);

    always_comb begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (job_ready) begin
            cur_next  = job;
            idx_next  = '0;
            busy_next = job_valid;
        end else if (m_ready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ----- hw/rtl/base64_stream_codec.sv -----
// Top level of the streaming Base64 codec (standard alphabet, '=' padding).
// Instantiates b64_front, b64_queue and b64_back; uses b64_pkg.
//
// Usage:
//   The input channel (s_valid/s_ready) carries one request per byte: s_data_byte
//   and s_msg_end, which marks the last byte of a message. The result channel
//   (m_valid/m_ready) carries one character or byte per request in m_out_byte,
//   up to four of them for one input request, with m_run_last on the last result
//   caused by an input request and m_msg_done on the last result caused by a
//   message-ending request. The configuration channel (cfg_valid/cfg_ready/cfg_data)
//   writes the mode: 0 encodes bytes to text, 1 decodes text to bytes. A mode write
//   also clears the partial group. Write the mode only while the codec is idle.
//
// Timing:
//   With the back end idle, the job of an accepted request passes through the queue
//   entry and the back-end job register before its first result is valid.
//   The back end emits one result per cycle while m_ready is high.
//   Requests that produce no result put no job into the queue.
//   The job queue (QUEUE_DEPTH entries) decouples the two sides: when the
//   receiver stalls, results hold on the output and s_ready drops once the
//   queue is full. Reset returns the mode to encode and empties the queue.
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_msg_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_msg_done
);
    import b64_pkg::*;

    logic in_fire;
    logic cfg_fire;
    logic q_push_valid, q_push_ready;
    logic q_pop_valid,  q_pop_ready;
    job_t q_push_job,   q_pop_job;

    // The mode register always takes a write at once.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // A request is taken whenever the queue has room for its job.
    assign s_ready = q_push_ready;
    assign in_fire = s_valid && s_ready;

    b64_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_fire),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_byte   (s_data_byte),
        .in_end    (s_msg_end),
        .job_valid (q_push_valid),
        .job       (q_push_job)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_job   (q_push_job),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_job    (q_pop_job)
    );

    b64_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (q_pop_valid),
        .job_ready  (q_pop_ready),
        .job        (q_pop_job),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last),
        .m_msg_done (m_msg_done)
    );

    // A job is only produced for an accepted request, so the queue never refuses one.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push_valid |-> q_push_ready)
        else $error("job produced while queue full");

    // A popped job always shows up on the output in the next cycle.
    a_pop_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop_valid && q_pop_ready |=> m_valid)
        else $error("popped job did not reach the output");

    // Message completion is only flagged on the last result of a request.
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_msg_done |-> m_run_last)
        else $error("msg_done without run_last");

    // Every job carries at least one result.
    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push_valid |-> q_push_job.count != 3'd0)
        else $error("empty job pushed");

endmodule
